### hw/rtl/twg_pkg.sv
// Package for the tone and waveform generator: item types, codes, tables and the sine builder.
package twg_pkg;

	// Default build parameters.
	localparam int unsigned DEF_SINE_TABLE_BITS = 10;
	localparam int unsigned DEF_SAMPLE_BITS     = 16;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 31;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_PER_HZ = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TONE_LENGTH  = 1'd1;

	localparam logic [30:0] PHASE_PER_HZ_RESET = 31'd137438953;
	localparam logic [23:0] TONE_LENGTH_RESET  = 24'd8000;

	// Mode codes.
	localparam logic [2:0] MODE_SINE     = 3'd0;
	localparam logic [2:0] MODE_SQUARE   = 3'd1;
	localparam logic [2:0] MODE_TRIANGLE = 3'd2;
	localparam logic [2:0] MODE_SAWTOOTH = 3'd3;
	localparam logic [2:0] MODE_DTMF     = 3'd4;
	localparam logic [2:0] MODE_SILENCE  = 3'd5;

	// DTMF row and column frequencies in hertz.
	localparam logic [10:0] ROW_HZ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
	localparam logic [10:0] COL_HZ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

	// Fixed-point constants used when building the sine table.
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	// One input item: one sample tick.
	typedef struct packed {
		logic        start_req;
		logic [2:0]  mode;
		logic [7:0]  key;
		logic [14:0] hertz;
	} twg_in_t;

	// One result item: one output sample and its flags.
	typedef struct packed {
		logic signed [15:0] sample;
		logic               in_tone;
		logic               last;
		logic               bad_key;
	} twg_out_t;

	// Decoded DTMF key.
	typedef struct packed {
		logic       valid;
		logic [1:0] row;
		logic [1:0] col;
	} twg_key_t;

	// Maps an ASCII key character to its row and column.
	function automatic twg_key_t dtmf_decode(logic [7:0] key);
		twg_key_t d;
		d = '{valid: 1'b1, row: 2'd0, col: 2'd0};
		unique case (key)
			"1":      begin d.row = 2'd0; d.col = 2'd0; end
			"2":      begin d.row = 2'd0; d.col = 2'd1; end
			"3":      begin d.row = 2'd0; d.col = 2'd2; end
			"a", "A": begin d.row = 2'd0; d.col = 2'd3; end
			"4":      begin d.row = 2'd1; d.col = 2'd0; end
			"5":      begin d.row = 2'd1; d.col = 2'd1; end
			"6":      begin d.row = 2'd1; d.col = 2'd2; end
			"b", "B": begin d.row = 2'd1; d.col = 2'd3; end
			"7":      begin d.row = 2'd2; d.col = 2'd0; end
			"8":      begin d.row = 2'd2; d.col = 2'd1; end
			"9":      begin d.row = 2'd2; d.col = 2'd2; end
			"c", "C": begin d.row = 2'd2; d.col = 2'd3; end
			"*":      begin d.row = 2'd3; d.col = 2'd0; end
			"0":      begin d.row = 2'd3; d.col = 2'd1; end
			"#":      begin d.row = 2'd3; d.col = 2'd2; end
			"d", "D": begin d.row = 2'd3; d.col = 2'd3; end
			default:  d.valid = 1'b0;
		endcase
		return d;
	endfunction

	// Sine magnitude for quarter-wave entry idx of 2^qb, rounded to sb-1 fraction bits.
	// Only ever called with constant arguments, so it folds away at elaboration.
	function automatic logic [31:0] sine_mag(int unsigned idx, int unsigned qb,
		int unsigned sb);
		logic [63:0] r;
		logic [63:0] th;
		logic [63:0] t2;
		logic [63:0] a;
		logic [63:0] s;
		logic [63:0] mag;
		logic [63:0] fmax;
		r    = 64'(idx) << (30 - qb);
		th   = (r * Q30_HALF_PI) >> 30;
		t2   = (th * th) >> 30;
		a    = Q30_ONE - t2 / 110;
		a    = Q30_ONE - ((t2 * a) >> 30) / 72;
		a    = Q30_ONE - ((t2 * a) >> 30) / 42;
		a    = Q30_ONE - ((t2 * a) >> 30) / 20;
		a    = Q30_ONE - ((t2 * a) >> 30) / 6;
		s    = (th * a) >> 30;
		mag  = ((s << (sb - 1)) + (64'd1 << 29)) >> 30;
		fmax = (64'd1 << (sb - 1)) - 64'd1;
		if (mag > fmax) begin
			mag = fmax;
		end
		return 32'(mag);
	endfunction

endpackage

### hw/rtl/twg_sine.sv
// Quarter-wave sine lookup: folds a 32-bit phase onto a constant table and restores the sign.
module twg_sine #(
	parameter int unsigned TABLE_BITS  = twg_pkg::DEF_SINE_TABLE_BITS,
	parameter int unsigned SAMPLE_BITS = twg_pkg::DEF_SAMPLE_BITS
) (
	input  logic [31:0]                   phase,
	output logic signed [SAMPLE_BITS-1:0] value
);
	import twg_pkg::*;

	localparam int unsigned QB    = TABLE_BITS - 2;
	localparam int unsigned QN    = 2 ** QB;
	localparam int unsigned IDX_W = QB + 1;
	localparam int unsigned MAG_W = SAMPLE_BITS - 1;

	logic [MAG_W-1:0] qtab [QN+1];
	logic [1:0]       quad;
	logic [QB-1:0]    m;
	logic [IDX_W-1:0] idx;
	logic [MAG_W-1:0] mag;

	// Constant quarter-wave table, one entry more so that the peak has its own slot.
	for (genvar g = 0; g <= QN; g++) begin : g_tab
		assign qtab[g] = MAG_W'(sine_mag(g, QB, SAMPLE_BITS));
	end

	// Top table bits of the phase select quadrant and offset.
	assign quad = phase[31 -: 2];
	assign m    = phase[29 -: QB];

	// Odd quadrants run the table backwards; the lower half is negated.
	assign idx   = quad[0] ? (IDX_W'(QN) - {1'b0, m}) : {1'b0, m};
	assign mag   = qtab[idx];
	assign value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

### hw/rtl/tone_and_waveform_generator.sv
// Top level of the tone and waveform generator: tick handshake, tone state and sample synthesis.

// Takes one tick item per clock cycle while tick_stall is low and returns one sample item for
// each, through an input register and a result register. All work for a tick is combinational
// between those registers: the phase step multiply at the start of a tone, the phase
// accumulator update, and up to two reads of a quarter-wave sine table. A tick with start_req
// set latches mode, key and hertz and clears phases and sample count; its own sample is the
// first of the new tone. A new phase_per_hz is used from the next start, a new tone_length at
// once. The block stalls input only while a finished sample waits and the one behind it is
// ready too.
module tone_and_waveform_generator #(
	parameter int unsigned SINE_TABLE_BITS = twg_pkg::DEF_SINE_TABLE_BITS,
	parameter int unsigned SAMPLE_BITS     = twg_pkg::DEF_SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [twg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [twg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           tick_valid,
	output logic                           tick_stall,
	input  twg_pkg::twg_in_t               tick_item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output twg_pkg::twg_out_t              result_item
);
	import twg_pkg::*;

	localparam int unsigned SB = SAMPLE_BITS;
	localparam logic [SB-1:0] MAX_CODE = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] MIN_CODE = {1'b1, {(SB-1){1'b0}}};

	// Configuration registers.
	logic [30:0] pph_q;
	logic [23:0] len_q;

	// Tone state.
	logic [31:0] ph1_q, ph2_q, st1_q, st2_q;
	logic [23:0] idx_q;
	logic [2:0]  mode_q;
	logic        kerr_q;

	// Pipeline registers.
	twg_in_t  item_s1;
	logic     valid_s1;
	twg_out_t out_q;
	logic     out_valid_q;

	logic out_ready, adv, accept;

	// Per-tick combinational signals.
	logic                 start;
	logic [2:0]           mode_in;
	logic [2:0]           mode_n;
	twg_key_t             kd;
	logic                 dtmf_ok;
	logic                 kerr_n;
	logic [14:0]          hz1;
	logic [45:0]          prod1, prod2;
	logic [31:0]          st1_new, st2_new, st1_n, st2_n;
	logic [31:0]          ph1, ph2, ph1_n, ph2_n;
	logic [23:0]          idx, idx_n;
	logic                 in_tone, last;
	logic signed [SB-1:0] sin1, sin2, v;
	logic [SB-1:0]        tri_t;
	logic signed [SB:0]   dsum;
	logic signed [15:0]   q15;

	// Handshake: the input register moves on whenever the result register can take it.
	assign out_ready    = !out_valid_q || !result_stall;
	assign adv          = valid_s1 && out_ready;
	assign tick_stall   = valid_s1 && !out_ready;
	assign accept       = tick_valid && !tick_stall;
	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pph_q <= PHASE_PER_HZ_RESET;
			len_q <= TONE_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_PER_HZ: pph_q <= cfg_data;
				CFG_TONE_LENGTH:  len_q <= cfg_data[23:0];
			endcase
		end
	end

	// Tone parameters chosen at a start tick; undefined modes fall back to silence.
	assign start   = item_s1.start_req;
	assign mode_in = (item_s1.mode > MODE_SILENCE) ? MODE_SILENCE : item_s1.mode;
	assign mode_n  = start ? mode_in : mode_q;
	assign kd      = dtmf_decode(item_s1.key);
	assign dtmf_ok = (mode_in == MODE_DTMF) && kd.valid;
	assign kerr_n  = start ? ((mode_in == MODE_DTMF) && !kd.valid) : kerr_q;

	// Phase steps: hertz times phase_per_hz, shifted right by eight, kept to 32 bits.
	assign hz1     = (mode_in == MODE_DTMF) ? 15'(ROW_HZ[kd.row]) : item_s1.hertz;
	assign prod1   = 46'(hz1) * 46'(pph_q);
	assign prod2   = 46'(COL_HZ[kd.col]) * 46'(pph_q);
	assign st1_new = ((mode_in <= MODE_SAWTOOTH) || dtmf_ok) ? prod1[39:8] : 32'd0;
	assign st2_new = dtmf_ok ? prod2[39:8] : 32'd0;
	assign st1_n   = start ? st1_new : st1_q;
	assign st2_n   = start ? st2_new : st2_q;

	// Current phase and sample count; a start tick begins from zero.
	assign ph1 = start ? 32'd0 : ph1_q;
	assign ph2 = start ? 32'd0 : ph2_q;
	assign idx = start ? 24'd0 : idx_q;

	assign in_tone = idx < len_q;
	assign last    = in_tone && (({1'b0, idx} + 25'd1) == {1'b0, len_q});

	// Phases and count advance only inside the tone.
	assign ph1_n = !in_tone ? ph1 : (start ? st1_new : ph1_q + st1_q);
	assign ph2_n = !in_tone ? ph2 : (start ? st2_new : ph2_q + st2_q);
	assign idx_n = in_tone ? idx + 24'd1 : idx;

	twg_sine #(
		.TABLE_BITS  (SINE_TABLE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sine1 (
		.phase (ph1),
		.value (sin1)
	);

	twg_sine #(
		.TABLE_BITS  (SINE_TABLE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sine2 (
		.phase (ph2),
		.value (sin2)
	);

	// Waveform selection. The DTMF mix is the floored mean of the two sines.
	assign tri_t = ph1[30 -: SB];
	assign dsum  = {sin1[SB-1], sin1} + {sin2[SB-1], sin2};

	always_comb begin
		v = '0;
		if (in_tone) begin
			unique case (mode_n)
				MODE_SINE:     v = sin1;
				MODE_SQUARE:   v = ph1[31] ? MAX_CODE : MIN_CODE;
				MODE_TRIANGLE: begin
					if (!ph1[31]) begin
						v = {~tri_t[SB-1], tri_t[SB-2:0]};
					end else if (tri_t == '0) begin
						v = MAX_CODE;
					end else begin
						v = MIN_CODE - tri_t;
					end
				end
				MODE_SAWTOOTH: v = {~ph1[31], ph1[30 -: SB-1]};
				MODE_DTMF:     v = kerr_n ? '0 : dsum[SB:1];
				default:       v = '0;
			endcase
		end
	end

	// Conversion to Q1.15: floor for wider samples, left shift for narrower ones.
	if (SB >= 16) begin : g_narrow
		assign q15 = 16'(v >>> (SB - 16));
	end else begin : g_widen
		logic signed [15:0] v_ext;
		assign v_ext = 16'(v);
		assign q15   = v_ext <<< (16 - SB);
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= tick_item;
		end
	end

	// Tone state update, once per tick that moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph1_q  <= '0;
			ph2_q  <= '0;
			st1_q  <= '0;
			st2_q  <= '0;
			idx_q  <= '0;
			mode_q <= MODE_SILENCE;
			kerr_q <= 1'b0;
		end else if (adv) begin
			ph1_q  <= ph1_n;
			ph2_q  <= ph2_n;
			st1_q  <= st1_n;
			st2_q  <= st2_n;
			idx_q  <= idx_n;
			mode_q <= mode_n;
			kerr_q <= kerr_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.sample  <= q15;
			out_q.in_tone <= in_tone;
			out_q.last    <= last;
			out_q.bad_key <= kerr_n;
		end
	end

endmodule

### hw/rtl/twg_checker.sv
// Port-level checks for the tone and waveform generator, bound to its top level.
module twg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              tick_stall,
	input logic              result_valid,
	input logic              result_stall,
	input twg_pkg::twg_out_t result_item
);
	import twg_pkg::*;

	// A stalled result item stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result item changed or was withdrawn");

	// Input is held back only while a result item waits at a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> result_valid && result_stall)
		else $error("tick stalled without a blocked result item");

	// The final sample of a tone lies inside the tone.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.last |-> result_item.in_tone)
		else $error("last flagged outside the tone");

	// Outside the tone the sample is silent.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.in_tone |-> result_item.sample == 16'sd0)
		else $error("non-zero sample outside the tone");

	// An invalid DTMF key gives silence.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.bad_key |-> result_item.sample == 16'sd0)
		else $error("non-zero sample with a bad key");

endmodule

bind tone_and_waveform_generator twg_checker u_twg_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the tone and waveform generator, with its own sample predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import twg_pkg::*;

	// Keypad layout in row-major order, and the characters that form valid keys.
	localparam logic [127:0] KEYPAD    = "123A456B789C*0#D";
	localparam logic [159:0] KEY_CHARS = "0123456789*#ABCDabcd";

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   tick_valid;
	logic                   tick_stall;
	twg_in_t                tick_item;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	twg_out_t               result_item;

	// Predictor state: tone generator registers and configuration.
	logic [31:0] acc_row = '0;
	logic [31:0] acc_col = '0;
	logic [31:0] inc_row = '0;
	logic [31:0] inc_col = '0;
	logic [23:0] tone_pos = '0;
	logic [2:0]  tone_mode = MODE_SILENCE;
	logic        tone_bad_key = 1'b0;
	logic [30:0] ppz_setting = PHASE_PER_HZ_RESET;
	logic [23:0] length_setting = TONE_LENGTH_RESET;

	twg_out_t pending_samples[$];
	twg_out_t expected_item;
	int       errors = 0;
	bit       quiet = 1'b0;
	int       rx_hold_req = 0;
	int       rx_hold_left = 0;
	int       rx_burst_left = 0;

	tone_and_waveform_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick_item    (tick_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always #4 clk = ~clk;

	// Phase step for a frequency under the current phase-per-hertz setting.
	function automatic logic [31:0] phase_step(input logic [14:0] hz);
		logic [63:0] prod;
		prod = 64'(hz) * 64'(ppz_setting);
		return prod[39:8];
	endfunction

	// Quarter-wave sine table entry for a phase, as a Q1.15 value.
	function automatic int table_sine(input logic [31:0] phase);
		logic [9:0]  idx;
		logic [63:0] r;
		logic [63:0] th;
		logic [63:0] t2;
		logic [63:0] a;
		logic [63:0] s;
		logic [63:0] mag;
		idx = phase[31:22];
		r   = 64'(idx[7:0]) << 22;
		if (idx[8]) begin
			r = Q30_ONE - r;
		end
		th  = (r * Q30_HALF_PI) >> 30;
		t2  = (th * th) >> 30;
		a   = Q30_ONE - t2 / 110;
		a   = Q30_ONE - ((t2 * a) >> 30) / 72;
		a   = Q30_ONE - ((t2 * a) >> 30) / 42;
		a   = Q30_ONE - ((t2 * a) >> 30) / 20;
		a   = Q30_ONE - ((t2 * a) >> 30) / 6;
		s   = (th * a) >> 30;
		mag = ((s << 15) + (64'd1 << 29)) >> 30;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		return idx[9] ? -int'(mag) : int'(mag);
	endfunction

	// Advances the predictor by one tick and returns the sample it should produce.
	function automatic twg_out_t next_sample(input twg_in_t t);
		twg_out_t   res;
		int         v;
		int         pos;
		int         i;
		logic [7:0] k;
		logic [31:0] p;
		logic       in_tone;
		v   = 0;
		pos = -1;
		if (t.start_req) begin
			tone_mode    = (t.mode > MODE_SILENCE) ? MODE_SILENCE : t.mode;
			acc_row      = '0;
			acc_col      = '0;
			inc_row      = '0;
			inc_col      = '0;
			tone_pos     = '0;
			tone_bad_key = 1'b0;
			if (tone_mode == MODE_DTMF) begin
				// Lower-case a to d fold onto the upper-case keys.
				k = t.key;
				if (k >= "a" && k <= "d") begin
					k = k - 8'd32;
				end
				for (i = 0; i < 16; i++) begin
					if (KEYPAD[127 - 8 * i -: 8] == k) begin
						pos = i;
					end
				end
				if (pos < 0) begin
					tone_bad_key = 1'b1;
				end else begin
					inc_row = phase_step(15'(ROW_HZ[pos / 4]));
					inc_col = phase_step(15'(COL_HZ[pos % 4]));
				end
			end else if (tone_mode != MODE_SILENCE) begin
				inc_row = phase_step(t.hertz);
			end
		end

		in_tone     = tone_pos < length_setting;
		res.in_tone = in_tone;
		res.last    = in_tone && (25'(tone_pos) + 25'd1 == 25'(length_setting));
		res.bad_key = tone_bad_key;

		// Waveform synthesis from the current phase, then the phases advance.
		if (in_tone) begin
			p = acc_row;
			unique case (tone_mode)
				MODE_SINE: begin
					v = table_sine(p);
				end
				MODE_SQUARE: begin
					v = p[31] ? 32767 : -32768;
				end
				MODE_TRIANGLE: begin
					if (!p[31]) begin
						v = int'(p >> 15) - 32768;
					end else begin
						v = 98304 - int'(p >> 15);
						if (v > 32767) begin
							v = 32767;
						end
					end
				end
				MODE_SAWTOOTH: begin
					v = int'(p >> 16) - 32768;
				end
				MODE_DTMF: begin
					if (!tone_bad_key) begin
						v = (table_sine(acc_row) + table_sine(acc_col)) >>> 1;
					end
				end
				default: begin
					v = 0;
				end
			endcase
			acc_row  = acc_row + inc_row;
			acc_col  = acc_col + inc_col;
			tone_pos = tone_pos + 24'd1;
		end
		res.sample = v[15:0];
		return res;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// Register writes, accepted ticks and returned samples, all seen at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_samples.size() == 0) begin
					$display("%0t ns: sample item with none expected, actual %0d", $time,
						int'(result_item.sample));
					errors++;
				end else begin
					expected_item = pending_samples.pop_front();
					check_field("sample", int'(expected_item.sample), int'(result_item.sample));
					check_field("in_tone", expected_item.in_tone, result_item.in_tone);
					check_field("last", expected_item.last, result_item.last);
					check_field("bad_key", expected_item.bad_key, result_item.bad_key);
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PHASE_PER_HZ: ppz_setting = cfg_data;
					CFG_TONE_LENGTH:  length_setting = cfg_data[23:0];
					default:          ;
				endcase
			end
			if (tick_valid && !tick_stall) begin
				pending_samples.push_back(next_sample(tick_item));
			end
		end
	end

	// Sample receiver: random stall bursts, plus a long hold when a test asks for one.
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			result_stall <= 1'b1;
		end else if (rx_burst_left != 0) begin
			rx_burst_left--;
			result_stall <= 1'b1;
		end else if (arst_n && !quiet && $urandom_range(0, 9) == 0) begin
			rx_burst_left = $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic twg_in_t make_tick(input logic s, input logic [2:0] m, input logic [7:0] k,
		input logic [14:0] hz);
		twg_in_t t;
		t.start_req = s;
		t.mode      = m;
		t.key       = k;
		t.hertz     = hz;
		return t;
	endfunction

	function automatic logic [14:0] random_hertz();
		unique case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return 15'($urandom_range(20, 4000));
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	// A tick with random content; the start flag is random only when asked.
	function automatic twg_in_t random_tick(input bit any_start);
		return make_tick(any_start ? 1'($urandom_range(0, 1)) : 1'b0, 3'($urandom_range(0, 7)),
			8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)));
	endfunction

	// A tone start, mostly with a valid key when the mode is DTMF.
	function automatic twg_in_t random_tone_start();
		twg_in_t t;
		t = make_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
			random_hertz());
		if (t.mode == MODE_DTMF && $urandom_range(0, 9) != 0) begin
			t.key = KEY_CHARS[159 - 8 * $urandom_range(0, 19) -: 8];
		end
		return t;
	endfunction

	// Offers one item until it is taken, then sometimes idles for a short burst.
	task automatic send_tick(input twg_in_t t);
		tick_item  <= t;
		tick_valid <= 1'b1;
		do @(posedge clk); while (tick_stall);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every expected sample has been returned.
	task automatic wait_for_samples();
		tick_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic configure(input logic [30:0] ppz, input logic [23:0] len);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PHASE_PER_HZ;
		cfg_data  <= ppz;
		@(posedge clk);
		cfg_index <= CFG_TONE_LENGTH;
		cfg_data  <= 31'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// After reset the block runs a silent tone of the default length.
	task automatic test_reset_state();
		repeat (3) send_tick(random_tick(1'b0));
	endtask

	// Every mode code, the undefined ones too, each with a start and one further tick.
	task automatic test_waveforms();
		logic [2:0]  m;
		logic [14:0] hz;
		m  = MODE_SINE;
		hz = 15'd1000;
		repeat (8) begin
			send_tick(make_tick(1'b1, m, "5", hz));
			send_tick(random_tick(1'b0));
			m++;
			hz = hz + 15'd700;
		end
	endtask

	// Valid and invalid DTMF keys, and the frequency extremes.
	task automatic test_dtmf_and_extremes();
		send_tick(make_tick(1'b1, MODE_DTMF, "d", '0));
		send_tick(make_tick(1'b1, MODE_DTMF, 8'hFF, '1));
		send_tick(random_tick(1'b0));
		send_tick(make_tick(1'b1, MODE_DTMF, 8'h00, '0));
		send_tick(make_tick(1'b1, MODE_SINE, "1", '0));
		send_tick(make_tick(1'b1, MODE_SAWTOOTH, "#", '1));
	endtask

	// Short tones run past their end; a zero length keeps every sample out of the tone.
	task automatic test_tone_end();
		wait_for_samples();
		configure('1, 24'd2);
		send_tick(make_tick(1'b1, MODE_TRIANGLE, "*", 15'd12345));
		repeat (3) send_tick(random_tick(1'b0));
		wait_for_samples();
		configure('0, '0);
		send_tick(make_tick(1'b1, MODE_SQUARE, "0", 15'd500));
		send_tick(random_tick(1'b0));
		wait_for_samples();
	endtask

	// Random tones of random length, with some fully random ticks as noise.
	task automatic run_random_tones(input int item_count, input bit hold_receiver);
		int sent;
		int run;
		sent = 0;
		if (hold_receiver) begin
			rx_hold_req = 200;
		end
		while (sent < item_count) begin
			if ($urandom_range(0, 9) == 0) begin
				send_tick(random_tick(1'b1));
			end else begin
				send_tick(random_tone_start());
			end
			run = $urandom_range(0, 40);
			repeat (run) send_tick(random_tick(1'b0));
			sent += run + 1;
		end
		wait_for_samples();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		tick_valid = 1'b0;
		tick_item  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_waveforms();
		test_dtmf_and_extremes();
		test_tone_end();

		configure(PHASE_PER_HZ_RESET, 24'($urandom_range(20, 80)));
		run_random_tones(250, 1'b0);
		configure('1, 24'd1);
		run_random_tones(150, 1'b0);
		configure(31'($urandom), 24'($urandom_range(10, 200)));
		run_random_tones(250, 1'b1);
		configure('0, '1);
		run_random_tones(100, 1'b0);
		configure(31'($urandom), '0);
		run_random_tones(60, 1'b0);

		// Closing stretch at full rate on both sides.
		quiet = 1'b1;
		configure(PHASE_PER_HZ_RESET, 24'($urandom_range(5, 60)));
		run_random_tones(300, 1'b0);

		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
